[hdl/lebuf_pkg.sv]
// Shared types and constants for the line edit buffer with echo.
package lebuf_pkg;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_NOLINE = 2'd2;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_char;
        logic [6:0] read_count;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [6:0] read_total;
        logic       last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO,
        ST_BS_CHK,
        ST_BS1,
        ST_BS2,
        ST_BS3,
        ST_SCAN,
        ST_EMIT,
        ST_NOLINE
    } state_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ECHO_CHAR,
        OUT_ECHO_BS,
        OUT_ECHO_SPACE,
        OUT_ECHO_BS_LAST,
        OUT_DATA,
        OUT_NOLINE
    } out_sel_t;

    typedef struct packed {
        logic     take_char;
        logic     take_read;
        logic     take_bs;
        logic     bs_commit;
        logic     scan_step;
        logic     scan_hit;
        logic     emit_step;
        logic     emit_done;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic op_read;
        logic is_bs;
        logic room;
        logic fill_zero;
        logic rd_is_nl;
        logic scan_end;
        logic want_zero;
        logic emit_last;
        logic slot_free;
    } sts_t;

endpackage

[hdl/lebuf_ctrl.sv]
// Controller state machine for the line edit buffer.
module lebuf_ctrl
    import lebuf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (sts.op_read)
                    begin
                        cmd.take_read = 1'b1;
                        state_next = sts.fill_zero ? ST_NOLINE : ST_SCAN;
                    end
                    else if (sts.is_bs)
                    begin
                        cmd.take_bs = 1'b1;
                        state_next  = ST_BS_CHK;
                    end
                    else if (sts.room)
                    begin
                        cmd.take_char = 1'b1;
                        state_next    = ST_ECHO;
                    end
                end
            end
            ST_ECHO:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel = OUT_ECHO_CHAR;
                    state_next  = ST_IDLE;
                end
            end
            ST_BS_CHK:
            begin
                // empty buffer or a finished line: nothing to erase
                if (sts.fill_zero || sts.rd_is_nl)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.bs_commit = 1'b1;
                    state_next    = ST_BS1;
                end
            end
            ST_BS1:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel = OUT_ECHO_BS;
                    state_next  = ST_BS2;
                end
            end
            ST_BS2:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel = OUT_ECHO_SPACE;
                    state_next  = ST_BS3;
                end
            end
            ST_BS3:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel = OUT_ECHO_BS_LAST;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.rd_is_nl)
                begin
                    if (sts.want_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_hit = 1'b1;
                        state_next   = ST_EMIT;
                    end
                end
                else if (sts.scan_end)
                begin
                    state_next = ST_NOLINE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel   = OUT_DATA;
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_NOLINE:
            begin
                if (sts.slot_free)
                begin
                    cmd.out_sel = OUT_NOLINE;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/lebuf_dp.sv]
// Datapath: circular line store, pointers, counters and output register.
module lebuf_dp
    import lebuf_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PTR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CNT_W = $clog2(LINE_BYTES + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [SUM_W-1:0] DEPTH = SUM_W'(LINE_BYTES);

    logic [7:0] mem [LINE_BYTES];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [7:0]       char_reg;
    logic [6:0]       want_reg;
    logic [7:0]       rd_data_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [SUM_W-1:0] tail_sum, tail_m1_sum, adv_sum;
    logic [PTR_W-1:0] tail_ptr, tail_m1_ptr, adv_ptr, ptr_inc;
    logic [CNT_W-1:0] idx_p1, line_len;
    logic             want_fits;
    logic             slot_free;
    logic             wr_en;

    // address arithmetic, all values stay below twice the depth
    always_comb
    begin
        tail_sum    = SUM_W'(head_reg) + SUM_W'(fill_reg);
        tail_ptr    = PTR_W'((tail_sum >= DEPTH) ? tail_sum - DEPTH : tail_sum);
        tail_m1_sum = tail_sum - SUM_W'(1);
        tail_m1_ptr = PTR_W'((tail_m1_sum >= DEPTH) ? tail_m1_sum - DEPTH : tail_m1_sum);
        adv_sum     = SUM_W'(head_reg) + SUM_W'(total_reg);
        adv_ptr     = PTR_W'((adv_sum >= DEPTH) ? adv_sum - DEPTH : adv_sum);
        ptr_inc     = (SUM_W'(ptr_reg) == DEPTH - SUM_W'(1)) ? '0 : ptr_reg + PTR_W'(1);
        idx_p1      = idx_reg + CNT_W'(1);
        want_fits   = (8'(want_reg) <= 8'(idx_p1));
        line_len    = want_fits ? CNT_W'(want_reg) : idx_p1;
    end

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign wr_en     = cmd.take_char;

    always_comb
    begin
        sts.op_read   = (req.op == OP_READ);
        sts.is_bs     = (req.rx_char == CH_BACKSPACE);
        sts.room      = (fill_reg < CNT_W'(LINE_BYTES));
        sts.fill_zero = (fill_reg == '0);
        sts.rd_is_nl  = (rd_data_reg == CH_NEWLINE);
        sts.scan_end  = (idx_p1 == fill_reg);
        sts.want_zero = (want_reg == '0);
        sts.emit_last = (idx_p1 == total_reg);
        sts.slot_free = slot_free;
    end

    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        if (cmd.take_char)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.take_read)
        begin
            ptr_next = head_reg;
            idx_next = '0;
        end
        if (cmd.take_bs)
        begin
            ptr_next = tail_m1_ptr;
        end
        if (cmd.bs_commit)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        if (cmd.scan_step || cmd.emit_step)
        begin
            ptr_next = ptr_inc;
            idx_next = idx_p1;
        end
        if (cmd.scan_hit)
        begin
            total_next = line_len;
            ptr_next   = head_reg;
            idx_next   = '0;
        end
        if (cmd.emit_done)
        begin
            head_next = adv_ptr;
            fill_next = fill_reg - total_reg;
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.out_sel != OUT_NONE)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.kind       = KIND_ECHO;
            rsp_next.data_byte  = '0;
            rsp_next.read_total = '0;
            rsp_next.last       = 1'b0;
        end
        case (cmd.out_sel)
            OUT_ECHO_CHAR:
            begin
                rsp_next.data_byte = char_reg;
                rsp_next.last      = 1'b1;
            end
            OUT_ECHO_BS:
            begin
                rsp_next.data_byte = CH_BACKSPACE;
            end
            OUT_ECHO_SPACE:
            begin
                rsp_next.data_byte = CH_SPACE;
            end
            OUT_ECHO_BS_LAST:
            begin
                rsp_next.data_byte = CH_BACKSPACE;
                rsp_next.last      = 1'b1;
            end
            OUT_DATA:
            begin
                rsp_next.kind       = KIND_DATA;
                rsp_next.data_byte  = rd_data_reg;
                rsp_next.read_total = 7'(total_reg);
                rsp_next.last       = idx_p1 == total_reg;
            end
            OUT_NOLINE:
            begin
                rsp_next.kind = KIND_NOLINE;
                rsp_next.last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        rsp_reg   <= rsp_next;
        if (cmd.take_char)
        begin
            char_reg <= req.rx_char;
        end
        if (cmd.take_read)
        begin
            want_reg <= req.read_count;
        end
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_ptr] <= req.rx_char;
        end
        rd_data_reg <= mem[ptr_next];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hdl/line_edit_buffer_with_echo_core.sv]
// Top level of the line edit buffer with echo.
// Line edit buffer with echo: a cut-down canonical terminal line discipline.
// Received bytes (op = 0) go into a circular store of LINE_BYTES entries and
// are echoed as one item; a backspace erases the last byte and echoes
// backspace, space, backspace, unless the store is empty or ends in a newline;
// a byte that finds the store full is dropped with no item. A read (op = 1)
// delivers up to read_count bytes through the first newline, each as a data
// item carrying the delivered total, or one no-line item if no newline is
// stored. The store has a single read port, so a read walks it one entry a
// cycle, each output step waiting out any output stall. A received byte is
// stored, then echoed; a backspace is checked, then echoed as three items;
// a read scans to the newline, then emits. The store needs no clearing pass
// after reset; entries beyond the fill count are never read. A finished item
// waits in the output register while the next item is accepted.
module line_edit_buffer_with_echo_core
    import lebuf_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencing: accept, echo, backspace, scan, emit
    lebuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store, pointers and the output register
    lebuf_dp #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
